@@ src/ttt_pkg.sv @@
// ----------------------------------------------------------------------------
// ttt_pkg
// Shared types, widths, register codes and the two temperature curves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ttt_pkg;

   localparam int SAMPLE_W  = 12;
   localparam int TEMP_W    = 20;
   localparam int DIFF_W    = TEMP_W + 1;
   localparam int PROD_W    = DIFF_W + SAMPLE_W + 1;
   localparam int CURVE_LEN = 33;
   localparam int SEG_W     = 5;
   localparam int IDX_W     = 6;
   localparam int ADDR_W    = 4;
   localparam int REG_W     = 2;
   localparam int DATA_W    = 32;

   localparam logic [REG_W-1:0] REG_MARGIN_LOW  = 2'd0;
   localparam logic [REG_W-1:0] REG_MARGIN_HIGH = 2'd1;
   localparam logic [REG_W-1:0] REG_HIGH_LIMIT  = 2'd2;
   localparam logic [REG_W-1:0] REG_LOW_LIMIT   = 2'd3;

   localparam logic [SAMPLE_W-1:0]      RST_MARGIN_LOW  = 12'd50;
   localparam logic [SAMPLE_W-1:0]      RST_MARGIN_HIGH = 12'd4045;
   localparam logic signed [TEMP_W-1:0] RST_HIGH_LIMIT  = 20'sd280000;
   localparam logic signed [TEMP_W-1:0] RST_LOW_LIMIT   = -20'sd30000;

   typedef struct packed {
      logic [SAMPLE_W-1:0]      margin_low;
      logic [SAMPLE_W-1:0]      margin_high;
      logic signed [TEMP_W-1:0] high_limit;
      logic signed [TEMP_W-1:0] low_limit;
   } cfg_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] raw_sample;
      logic                sensor_kind;
      logic                adc_error;
   } sample_type;

   typedef struct packed {
      logic hardware_fault;
      logic open_circuit;
      logic short_circuit;
   } fault_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] y0;
      logic signed [DIFF_W-1:0] diff;
      logic [SAMPLE_W-1:0]      frac;
      fault_type                fault;
   } lookup_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] y0;
      logic signed [PROD_W-1:0] prod;
      fault_type                fault;
   } product_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temperature;
      fault_type                fault;
   } interp_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temperature;
      logic                     hardware_fault;
      logic                     open_circuit;
      logic                     short_circuit;
      logic                     high_temp;
      logic                     low_temp;
      logic                     any_fault;
   } result_type;

   function automatic logic signed [TEMP_W-1:0] cold_point(input logic [IDX_W-1:0] idx);
      logic signed [TEMP_W-1:0] y;
      case (idx)
         6'd0:  y = -20'sd40000;
         6'd1:  y = -20'sd25000;
         6'd2:  y = -20'sd14500;
         6'd3:  y = -20'sd6000;
         6'd4:  y = 20'sd1000;
         6'd5:  y = 20'sd7200;
         6'd6:  y = 20'sd13000;
         6'd7:  y = 20'sd18300;
         6'd8:  y = 20'sd23500;
         6'd9:  y = 20'sd28400;
         6'd10: y = 20'sd33200;
         6'd11: y = 20'sd37800;
         6'd12: y = 20'sd42500;
         6'd13: y = 20'sd47200;
         6'd14: y = 20'sd51900;
         6'd15: y = 20'sd56700;
         6'd16: y = 20'sd61700;
         6'd17: y = 20'sd66800;
         6'd18: y = 20'sd72200;
         6'd19: y = 20'sd77900;
         6'd20: y = 20'sd84000;
         6'd21: y = 20'sd90500;
         6'd22: y = 20'sd97600;
         6'd23: y = 20'sd105500;
         6'd24: y = 20'sd114300;
         6'd25: y = 20'sd124300;
         6'd26: y = 20'sd136100;
         6'd27: y = 20'sd150300;
         6'd28: y = 20'sd168500;
         6'd29: y = 20'sd193000;
         6'd30: y = 20'sd230000;
         6'd31: y = 20'sd280000;
         6'd32: y = 20'sd330000;
         default: y = '0;
      endcase
      return y;
   endfunction

   function automatic logic signed [TEMP_W-1:0] oven_point(input logic [IDX_W-1:0] idx);
      logic signed [TEMP_W-1:0] y;
      case (idx)
         6'd0:  y = 20'sd300000;
         6'd1:  y = 20'sd285000;
         6'd2:  y = 20'sd270000;
         6'd3:  y = 20'sd256000;
         6'd4:  y = 20'sd242000;
         6'd5:  y = 20'sd229000;
         6'd6:  y = 20'sd216000;
         6'd7:  y = 20'sd204000;
         6'd8:  y = 20'sd192000;
         6'd9:  y = 20'sd180000;
         6'd10: y = 20'sd169000;
         6'd11: y = 20'sd158000;
         6'd12: y = 20'sd147000;
         6'd13: y = 20'sd136000;
         6'd14: y = 20'sd126000;
         6'd15: y = 20'sd116000;
         6'd16: y = 20'sd106000;
         6'd17: y = 20'sd96000;
         6'd18: y = 20'sd86000;
         6'd19: y = 20'sd77000;
         6'd20: y = 20'sd68000;
         6'd21: y = 20'sd59000;
         6'd22: y = 20'sd50000;
         6'd23: y = 20'sd42000;
         6'd24: y = 20'sd34000;
         6'd25: y = 20'sd26000;
         6'd26: y = 20'sd19000;
         6'd27: y = 20'sd13000;
         6'd28: y = 20'sd8000;
         6'd29: y = 20'sd4000;
         6'd30: y = 20'sd2000;
         6'd31: y = 20'sd1000;
         6'd32: y = 20'sd0;
         default: y = '0;
      endcase
      return y;
   endfunction

endpackage

@@ src/ttt_if.sv @@
// ----------------------------------------------------------------------------
// ttt_req_if / ttt_rsp_if
// Valid/ready channels for samples in and temperature results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ttt_req_if;
   import ttt_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] raw_sample;
   logic                sensor_kind;
   logic                adc_error;

   modport source (output valid, raw_sample, sensor_kind, adc_error, input ready);
   modport sink   (input valid, raw_sample, sensor_kind, adc_error, output ready);
endinterface

interface ttt_rsp_if;
   import ttt_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] temperature;
   logic                     hardware_fault;
   logic                     open_circuit;
   logic                     short_circuit;
   logic                     high_temp;
   logic                     low_temp;
   logic                     any_fault;

   modport source (output valid, temperature, hardware_fault, open_circuit, short_circuit,
                   high_temp, low_temp, any_fault, input ready);
   modport sink   (input valid, temperature, hardware_fault, open_circuit, short_circuit,
                   high_temp, low_temp, any_fault, output ready);
endinterface

@@ src/ttt_csr.sv @@
// ----------------------------------------------------------------------------
// ttt_csr
// APB register file: fault margins and plausibility limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttt_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [ttt_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [ttt_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [ttt_pkg::DATA_W-1:0]   csr_prdata,
   output logic                         csr_pready,
   output ttt_pkg::cfg_type             cfg
);
   import ttt_pkg::*;

   cfg_type           cfg_ff;
   cfg_type           cfg_in;
   logic [REG_W-1:0]  reg_sel;
   logic              wr_en;

   assign reg_sel    = csr_paddr[ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_MARGIN_LOW:  cfg_in.margin_low  = csr_pwdata[SAMPLE_W-1:0];
            REG_MARGIN_HIGH: cfg_in.margin_high = csr_pwdata[SAMPLE_W-1:0];
            REG_HIGH_LIMIT:  cfg_in.high_limit  = csr_pwdata[TEMP_W-1:0];
            REG_LOW_LIMIT:   cfg_in.low_limit   = csr_pwdata[TEMP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_MARGIN_LOW:  csr_prdata = DATA_W'(cfg_ff.margin_low);
         REG_MARGIN_HIGH: csr_prdata = DATA_W'(cfg_ff.margin_high);
         REG_HIGH_LIMIT:  csr_prdata = DATA_W'(cfg_ff.high_limit);
         REG_LOW_LIMIT:   csr_prdata = DATA_W'(cfg_ff.low_limit);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.margin_low  <= RST_MARGIN_LOW;
         cfg_ff.margin_high <= RST_MARGIN_HIGH;
         cfg_ff.high_limit  <= RST_HIGH_LIMIT;
         cfg_ff.low_limit   <= RST_LOW_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ src/ttt_lookup.sv @@
// ----------------------------------------------------------------------------
// ttt_lookup
// Stage 1: segment select, curve read, slope and open/short margin checks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttt_lookup #(
   parameter int SEGMENTS      = 32,
   parameter int SEGMENT_SHIFT = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ttt_pkg::cfg_type       cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  ttt_pkg::sample_type    in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output ttt_pkg::lookup_type    out_data
);
   import ttt_pkg::*;

   localparam int SegMax = (SEGMENTS - 1 < CURVE_LEN - 2) ? SEGMENTS - 1 : CURVE_LEN - 2;
   localparam logic [SAMPLE_W-1:0] FracMask = SAMPLE_W'((1 << SEGMENT_SHIFT) - 1);

   logic [SAMPLE_W-1:0]      seg_full;
   logic [SEG_W-1:0]         seg;
   logic [IDX_W-1:0]         idx0;
   logic [IDX_W-1:0]         idx1;
   logic signed [TEMP_W-1:0] y0;
   logic signed [TEMP_W-1:0] y1;
   logic                     low_hit;
   logic                     high_hit;
   logic                     valid_ff;
   lookup_type               data_ff;
   lookup_type               data_in;

   assign seg_full = in_data.raw_sample >> SEGMENT_SHIFT;
   assign seg      = (seg_full > SAMPLE_W'(SegMax)) ? SEG_W'(SegMax) : seg_full[SEG_W-1:0];
   assign idx0     = IDX_W'(seg);
   assign idx1     = IDX_W'(seg) + IDX_W'(1);
   assign y0       = in_data.sensor_kind ? oven_point(idx0) : cold_point(idx0);
   assign y1       = in_data.sensor_kind ? oven_point(idx1) : cold_point(idx1);
   assign low_hit  = in_data.raw_sample <= cfg.margin_low;
   assign high_hit = in_data.raw_sample >= cfg.margin_high;

   always_comb begin
      data_in.y0                   = y0;
      data_in.diff                 = DIFF_W'(y1) - DIFF_W'(y0);
      data_in.frac                 = in_data.raw_sample & FracMask;
      data_in.fault.hardware_fault = in_data.adc_error;
      data_in.fault.open_circuit   = !in_data.adc_error &&
                                     (in_data.sensor_kind ? high_hit : low_hit);
      data_in.fault.short_circuit  = !in_data.adc_error &&
                                     (in_data.sensor_kind ? low_hit : high_hit);
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

@@ src/ttt_interp.sv @@
// ----------------------------------------------------------------------------
// ttt_interp
// Stages 2 and 3: slope times fraction, then floor shift and offset add.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttt_interp #(
   parameter int SEGMENT_SHIFT = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  ttt_pkg::lookup_type    in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output ttt_pkg::interp_type    out_data
);
   import ttt_pkg::*;

   logic                     mul_valid_ff;
   logic                     mul_ready;
   product_type              mul_ff;
   product_type              mul_in;
   logic                     add_valid_ff;
   logic                     add_ready;
   interp_type               add_ff;
   interp_type               add_in;
   logic signed [PROD_W-1:0] shifted;
   logic [DIFF_W-1:0]        sum;

   always_comb begin
      mul_in.y0    = in_data.y0;
      mul_in.prod  = in_data.diff * $signed({1'b0, in_data.frac});
      mul_in.fault = in_data.fault;
   end

   // arithmetic shift floors toward minus infinity
   assign shifted = mul_ff.prod >>> SEGMENT_SHIFT;
   assign sum     = DIFF_W'(mul_ff.y0) + shifted[DIFF_W-1:0];

   always_comb begin
      add_in.temperature = sum[TEMP_W-1:0];
      add_in.fault       = mul_ff.fault;
   end

   assign add_ready = !add_valid_ff || out_ready;
   assign mul_ready = !mul_valid_ff || add_ready;
   assign in_ready  = mul_ready;
   assign out_valid = add_valid_ff;
   assign out_data  = add_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         add_valid_ff <= 1'b0;
      end else begin
         if (mul_ready) begin
            mul_valid_ff <= in_valid;
         end
         if (add_ready) begin
            add_valid_ff <= mul_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_ready && in_valid) begin
         mul_ff <= mul_in;
      end
      if (add_ready && mul_valid_ff) begin
         add_ff <= add_in;
      end
   end

endmodule

@@ src/ttt_limits.sv @@
// ----------------------------------------------------------------------------
// ttt_limits
// Stage 4: plausibility limit checks, fault summary and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttt_limits (
   input  logic                   clock,
   input  logic                   reset,
   input  ttt_pkg::cfg_type       cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  ttt_pkg::interp_type    in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output ttt_pkg::result_type    out_data
);
   import ttt_pkg::*;

   logic       valid_ff;
   result_type data_ff;
   result_type data_in;

   always_comb begin
      data_in.temperature    = in_data.temperature;
      data_in.hardware_fault = in_data.fault.hardware_fault;
      data_in.open_circuit   = in_data.fault.open_circuit;
      data_in.short_circuit  = in_data.fault.short_circuit;
      data_in.high_temp      = in_data.temperature > cfg.high_limit;
      data_in.low_temp       = in_data.temperature < cfg.low_limit;
      data_in.any_fault      = data_in.hardware_fault || data_in.open_circuit ||
                               data_in.short_circuit || data_in.high_temp ||
                               data_in.low_temp;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

@@ src/thermistor_table_temperature.sv @@
// ----------------------------------------------------------------------------
// thermistor_table_temperature
// Converts a 12-bit thermistor sample into milli-degrees Celsius by linear
// interpolation over a 33-point cold-junction or oven curve, and flags open
// or shorted sensors, converter errors and out-of-range temperatures. The
// block takes one sample per clock and returns each result after it passes
// a four-stage pipeline (curve read, slope multiply, shift and add, limit
// check). A stalled output holds the pipeline but the input keeps
// accepting until every stage is full. Margins and limits are written over
// the APB port at 0x0, 0x4, 0x8 and 0xC.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module thermistor_table_temperature #(
   parameter int SEGMENTS      = 32,
   parameter int SEGMENT_SHIFT = 7
) (
   input  logic                         clock,
   input  logic                         reset,
   ttt_req_if.sink                      req,
   ttt_rsp_if.source                    rsp,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [ttt_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [ttt_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [ttt_pkg::DATA_W-1:0]   csr_prdata,
   output logic                         csr_pready
);
   import ttt_pkg::*;

   cfg_type     cfg;
   sample_type  sample;
   logic        lk_valid;
   logic        lk_ready;
   lookup_type  lk_data;
   logic        ip_valid;
   logic        ip_ready;
   interp_type  ip_data;
   result_type  result;

   assign sample.raw_sample  = req.raw_sample;
   assign sample.sensor_kind = req.sensor_kind;
   assign sample.adc_error   = req.adc_error;

   ttt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ttt_lookup #(
      .SEGMENTS      (SEGMENTS),
      .SEGMENT_SHIFT (SEGMENT_SHIFT)
   ) u_lookup (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_data   (sample),
      .out_valid (lk_valid),
      .out_ready (lk_ready),
      .out_data  (lk_data)
   );

   ttt_interp #(
      .SEGMENT_SHIFT (SEGMENT_SHIFT)
   ) u_interp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lk_valid),
      .in_ready  (lk_ready),
      .in_data   (lk_data),
      .out_valid (ip_valid),
      .out_ready (ip_ready),
      .out_data  (ip_data)
   );

   ttt_limits u_limits (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (ip_valid),
      .in_ready  (ip_ready),
      .in_data   (ip_data),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_data  (result)
   );

   assign rsp.temperature    = result.temperature;
   assign rsp.hardware_fault = result.hardware_fault;
   assign rsp.open_circuit   = result.open_circuit;
   assign rsp.short_circuit  = result.short_circuit;
   assign rsp.high_temp      = result.high_temp;
   assign rsp.low_temp       = result.low_temp;
   assign rsp.any_fault      = result.any_fault;

`ifndef SYNTHESIS
   // input only backs up once the result is stalled and every stage is full
   a_full_before_stall: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (rsp.valid && !rsp.ready && ip_valid && lk_valid))
      else $error("input stalled with a bubble in the pipeline");

   a_err_masks_wiring: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.hardware_fault |-> !rsp.open_circuit && !rsp.short_circuit)
      else $error("open/short flagged on a converter error transaction");

   a_any_fault: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.any_fault == (rsp.hardware_fault || rsp.open_circuit ||
                    rsp.short_circuit || rsp.high_temp || rsp.low_temp))
      else $error("any_fault disagrees with the individual flags");
`endif

endmodule
